// ----- rtl/irq_least_count_balancer_macros.svh -----
// Assertion macros for the interrupt balancer.
// Each check is clocked on clk_i and disabled while rst_ni is low.
`ifndef IRQ_LEAST_COUNT_BALANCER_MACROS_SVH
`define IRQ_LEAST_COUNT_BALANCER_MACROS_SVH
`ifndef SYNTH
`define LCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCB_ASSERT(lbl, prop, msg)
`define LCB_ASSERT_IMP(lbl, ante, cons, msg)
`define LCB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/irq_lcb_pkg.sv -----
package irq_lcb_pkg;

  // Default sizes
  localparam int MAX_CORES_DEF   = 16;
  localparam int IRQ_LINES_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BAL_EN    = 2'd0,
    CFG_SYM_IO    = 2'd1,
    CFG_ACT_CORES = 2'd2,
    CFG_PERIOD    = 2'd3
  } cfg_reg_e;

  // Register reset values
  localparam logic [4:0]  ACT_CORES_RST = 5'd1;
  localparam logic [15:0] PERIOD_RST    = 16'd10;

endpackage

// ----- rtl/irq_least_count_balancer.sv -----
// Least-count interrupt balancer.
// Input stream (s_*): one item per serviced interrupt, IRQ line and serving core.
// Output stream (m_*): exactly one result item per input item: EOI target,
// routing decision (valid, IRQ, least loaded core) and a counts-cleared flag.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i;
// write only while no item is in flight.
// Counts live in a single-port-write, registered-read RAM of
// 2^(clog2(MAX_CORES)+clog2(IRQ_LINES)) words. After reset a clearing pass
// zeroes one word a cycle; s_tready_o stays low.
// One item at a time: accept, RAM read and count update, then, if balancing
// is on, a restoring remainder unit works through the COUNT_WIDTH count bits,
// one bit each; a period hit scans N active cores through the RAM port,
// comparing on the shared subtractor, and, when any count is within one of
// saturation, zeroes them. An IRQ or core out of range skips the RAM and goes
// straight to the result. The sequencer is ready for the next item in the
// cycle after a result is loaded.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a later result holds in the sequencer until the
// receiver takes the earlier one.
module irq_least_count_balancer
  import irq_lcb_pkg::*;
#(
  parameter int MAX_CORES   = MAX_CORES_DEF,
  parameter int IRQ_LINES   = IRQ_LINES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input item: irq_number[3:0], serving_core[7:4]
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  // result item: eoi_to_apic[0], route_valid[1], route_irq[5:2],
  // target_core[9:6], counts_cleared[10], zero fill above
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int CORE_W    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int IRQ_W     = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
  localparam int ADDR_W    = CORE_W + IRQ_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CW        = COUNT_WIDTH;
  localparam int BCNT_W    = $clog2(COUNT_WIDTH);
  localparam int SUB_W     = ((CW > 17) ? CW : 17) + 1;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_INC   = 9'b000001000,
    ST_MOD   = 9'b000010000,
    ST_SCAN  = 9'b000100000,
    ST_ZERO  = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_SPARE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic        bal_en_q, sym_io_q;
  logic [4:0]  act_cores_q;
  logic [15:0] period_q;

  // item registers
  logic [3:0]        irq_raw_q, irq_raw_d;
  logic [IRQ_W-1:0]  irq_q, irq_d;
  logic [CORE_W-1:0] core_q, core_d;

  // remainder unit
  logic [CW-1:0]     dvd_q, dvd_d;
  logic [15:0]       rem_q, rem_d;
  logic [BCNT_W-1:0] bcnt_q, bcnt_d;

  // scan registers
  logic [CORE_W-1:0] idx_q, idx_d;
  logic              issue_q, issue_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [CORE_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [CW-1:0]     best_q, best_d;
  logic [CORE_W-1:0] tgt_q, tgt_d;
  logic              near_q, near_d;
  logic              rv_q, rv_d;
  logic              clr_flag_q, clr_flag_d;

  // clearing pass
  logic [ADDR_W-1:0] clr_q, clr_d;

  // output register
  logic                  m_tvalid_q, m_tvalid_d;
  logic [OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;

  // memory
  logic [CW-1:0]     mem [MEM_DEPTH];
  logic [CW-1:0]     rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0]     mem_wdata;

  // misc combinational
  logic [8:0]        irq_ext;
  logic [6:0]        core_ext, act_ext, n_cores, last_ext, tgt_ext;
  logic [CORE_W-1:0] last_idx;
  logic [15:0]       period_eff;
  logic              in_range;
  logic [16:0]       rem_shift;
  logic [SUB_W-1:0]  sub_a, sub_b, sub_diff;
  logic              sub_lt;
  logic [CW-1:0]     cnt_inc;
  logic              rd_near, near_now;
  logic              fin_load;

  // input decode and range check
  assign irq_ext  = 9'(s_tdata_i[3:0]);
  assign core_ext = 7'(s_tdata_i[7:4]);
  assign in_range = (irq_ext < 9'(IRQ_LINES)) && (core_ext < 7'(MAX_CORES));

  // active core count clamped to 1..MAX_CORES
  assign act_ext  = 7'(act_cores_q);
  assign n_cores  = (act_ext == 7'd0) ? 7'd1 :
                    ((act_ext > 7'(MAX_CORES)) ? 7'(MAX_CORES) : act_ext);
  assign last_ext = n_cores - 7'd1;
  assign last_idx = last_ext[CORE_W-1:0];

  assign period_eff = (period_q == 16'd0) ? 16'd1 : period_q;

  // shared subtractor: remainder step or scan compare
  assign rem_shift = {rem_q, dvd_q[CW-1]};
  always_comb begin
    if (state_q == ST_SCAN) begin
      sub_a = SUB_W'(rdata_q);
      sub_b = SUB_W'(best_q);
    end else begin
      sub_a = SUB_W'(rem_shift);
      sub_b = SUB_W'(period_eff);
    end
  end
  assign sub_diff = sub_a - sub_b;
  assign sub_lt   = sub_diff[SUB_W-1];

  // saturating increment and near-full detect on read data
  assign cnt_inc  = (&rdata_q) ? rdata_q : rdata_q + CW'(1);
  assign rd_near  = &rdata_q[CW-1:1];
  assign near_now = near_q | rd_near;

  assign fin_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    irq_raw_d  = irq_raw_q;
    irq_d      = irq_q;
    core_d     = core_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    bcnt_d     = bcnt_q;
    idx_d      = idx_q;
    issue_d    = 1'b0;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    best_d     = best_q;
    tgt_d      = tgt_q;
    near_d     = near_q;
    rv_d       = rv_q;
    clr_flag_d = clr_flag_q;
    clr_d      = clr_q;
    mem_we     = 1'b0;
    mem_waddr  = {core_q, irq_q};
    mem_wdata  = '0;
    mem_raddr  = {core_q, irq_q};

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          irq_raw_d  = s_tdata_i[3:0];
          irq_d      = irq_ext[IRQ_W-1:0];
          core_d     = core_ext[CORE_W-1:0];
          rv_d       = 1'b0;
          clr_flag_d = 1'b0;
          tgt_d      = '0;
          state_d    = in_range ? ST_READ : ST_FIN;
        end
      end
      ST_READ: begin
        state_d = ST_INC;
      end
      ST_INC: begin
        mem_we    = 1'b1;
        mem_wdata = cnt_inc;
        dvd_d     = cnt_inc;
        rem_d     = '0;
        bcnt_d    = BCNT_W'(CW - 1);
        state_d   = (bal_en_q && (cnt_inc != '0)) ? ST_MOD : ST_FIN;
      end
      ST_MOD: begin
        // one restoring remainder step per cycle
        rem_d  = sub_lt ? rem_shift[15:0] : sub_diff[15:0];
        dvd_d  = {dvd_q[CW-2:0], 1'b0};
        bcnt_d = bcnt_q - BCNT_W'(1);
        if (bcnt_q == '0) begin
          if (rem_d == '0) begin
            state_d = ST_SCAN;
            idx_d   = '0;
            issue_d = 1'b1;
            best_d  = '1;
            tgt_d   = '0;
            near_d  = 1'b0;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        // the compare uses the read data issued in the previous cycle
        mem_raddr = {idx_q, irq_q};
        if (issue_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
          if (idx_q == last_idx) begin
            issue_d = 1'b0;
          end else begin
            issue_d = 1'b1;
            idx_d   = idx_q + CORE_W'(1);
          end
        end
        if (cmp_vld_q) begin
          if (sub_lt) begin
            best_d = rdata_q;
            tgt_d  = cmp_idx_q;
          end
          near_d = near_now;
          if (cmp_idx_q == last_idx) begin
            rv_d       = 1'b1;
            clr_flag_d = near_now;
            idx_d      = '0;
            state_d    = near_now ? ST_ZERO : ST_FIN;
          end
        end
      end
      ST_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = {idx_q, irq_q};
        idx_d     = idx_q + CORE_W'(1);
        if (idx_q == last_idx) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result packing
  assign tgt_ext = 7'(tgt_q);
  always_comb begin
    m_tdata_d       = '0;
    m_tdata_d[0]    = sym_io_q;
    m_tdata_d[1]    = rv_q;
    m_tdata_d[5:2]  = rv_q ? irq_raw_q : 4'd0;
    m_tdata_d[9:6]  = rv_q ? tgt_ext[3:0] : 4'd0;
    m_tdata_d[10]   = clr_flag_q;
  end

  assign m_tvalid_d = fin_load ? 1'b1 : (m_tready_i ? 1'b0 : m_tvalid_q);

  // count memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      issue_q    <= 1'b0;
      cmp_vld_q  <= 1'b0;
      m_tvalid_q <= 1'b0;
      rv_q       <= 1'b0;
      clr_flag_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      issue_q    <= issue_d;
      cmp_vld_q  <= cmp_vld_d;
      m_tvalid_q <= m_tvalid_d;
      rv_q       <= rv_d;
      clr_flag_q <= clr_flag_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    irq_raw_q <= irq_raw_d;
    irq_q     <= irq_d;
    core_q    <= core_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    bcnt_q    <= bcnt_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    best_q    <= best_d;
    tgt_q     <= tgt_d;
    near_q    <= near_d;
    if (fin_load) begin
      m_tdata_q <= m_tdata_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_en_q    <= 1'b0;
      sym_io_q    <= 1'b0;
      act_cores_q <= ACT_CORES_RST;
      period_q    <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_BAL_EN:    bal_en_q    <= cfg_wdata_i[0];
        CFG_SYM_IO:    sym_io_q    <= cfg_wdata_i[0];
        CFG_ACT_CORES: act_cores_q <= cfg_wdata_i[4:0];
        CFG_PERIOD:    period_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  // checks
`include "irq_least_count_balancer_macros.svh"

  `LCB_ASSERT_NXT(a_one_item, s_tvalid_i && s_tready_o, !s_tready_o, "accepted twice in a row")
  `LCB_ASSERT_IMP(a_route_zero, m_tvalid_o && !m_tdata_o[1], m_tdata_o[10:2] == 9'd0, "stale route")
  `LCB_ASSERT_IMP(a_cmp_range, cmp_vld_q, cmp_idx_q <= last_idx, "scan past active cores")
  `LCB_ASSERT_IMP(a_ram_idle, state_q == ST_IDLE || state_q == ST_FIN, !mem_we, "stray RAM write")

endmodule

// ----- verif/irq_route_checker.sv -----
module irq_route_checker
  import irq_lcb_pkg::*;
#(
  parameter int MAX_CORES   = MAX_CORES_DEF,
  parameter int IRQ_LINES   = IRQ_LINES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    events_o,
  output int                    reroutes_o,
  output int                    clears_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t COUNT_FULL      = '1;
  localparam count_t COUNT_NEAR_FULL = COUNT_FULL - 1'b1;

  typedef struct packed {
    logic       eoi_apic;
    logic       route_valid;
    logic [3:0] route_irq;
    logic [3:0] target_core;
    logic       cleared;
  } route_result_t;

  // shadow of the count table and the registers
  count_t        irq_counts [MAX_CORES][IRQ_LINES];
  logic          bal_en;
  logic          sym_io;
  logic [4:0]    act_cores;
  logic [15:0]   bal_period;
  route_result_t expected_routes [$];

  // one serviced interrupt: bump its count, maybe pick a new target core
  function automatic route_result_t route_event(int irq, int core);
    route_result_t res;
    count_t        cnt;
    count_t        best;
    logic   [15:0] per;
    int            n;
    bit            near_full;
    res = '0;
    res.eoi_apic = sym_io;
    if (irq < IRQ_LINES && core < MAX_CORES) begin
      cnt = irq_counts[core][irq];
      if (cnt != COUNT_FULL) cnt = cnt + 1'b1;
      irq_counts[core][irq] = cnt;
      per = (bal_period == 0) ? 16'd1 : bal_period;
      if (bal_en && cnt != 0 && (cnt % per) == 0) begin
        n = (act_cores == 0) ? 1 : int'(act_cores);
        if (n > MAX_CORES) n = MAX_CORES;
        best = COUNT_FULL;
        near_full = 1'b0;
        // lowest count wins, lowest index on ties
        for (int i = 0; i < n; i++) begin
          if (irq_counts[i][irq] < best) begin
            best = irq_counts[i][irq];
            res.target_core = 4'(i);
          end
          if (irq_counts[i][irq] >= COUNT_NEAR_FULL) near_full = 1'b1;
        end
        res.route_valid = 1'b1;
        res.route_irq   = 4'(irq);
        if (near_full) begin
          for (int i = 0; i < n; i++) irq_counts[i][irq] = '0;
          res.cleared = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string why, route_result_t exp_res, route_result_t got_res,
                                 logic [OUT_DATA_W-12:0] fill);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("[%0t] %s", $realtime, why);
      $display("  expected eoi=%0b route=%0b irq=%0d core=%0d clr=%0b",
               exp_res.eoi_apic, exp_res.route_valid, exp_res.route_irq,
               exp_res.target_core, exp_res.cleared);
      $display("  actual   eoi=%0b route=%0b irq=%0d core=%0d clr=%0b fill=%0h",
               got_res.eoi_apic, got_res.route_valid, got_res.route_irq,
               got_res.target_core, got_res.cleared, fill);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t exp_res;
    route_result_t got_res;
    if (!rst_ni) begin
      foreach (irq_counts[c, q]) irq_counts[c][q] = '0;
      bal_en       = 1'b0;
      sym_io       = 1'b0;
      act_cores    = ACT_CORES_RST;
      bal_period   = PERIOD_RST;
      expected_routes.delete();
      mismatches_o = 0;
      events_o     = 0;
      reroutes_o   = 0;
      clears_o     = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_BAL_EN:    bal_en     = cfg_wdata_i[0];
          CFG_SYM_IO:    sym_io     = cfg_wdata_i[0];
          CFG_ACT_CORES: act_cores  = cfg_wdata_i[4:0];
          CFG_PERIOD:    bal_period = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      // accepted input item
      if (s_tvalid_i && s_tready_i) begin
        exp_res = route_event(s_tdata_i[3:0], s_tdata_i[7:4]);
        expected_routes.push_back(exp_res);
        events_o++;
        if (exp_res.route_valid) reroutes_o++;
        if (exp_res.cleared) clears_o++;
      end
      // accepted result item
      if (m_tvalid_i && m_tready_i) begin
        got_res = '{m_tdata_i[0], m_tdata_i[1], m_tdata_i[5:2], m_tdata_i[9:6], m_tdata_i[10]};
        if (expected_routes.size() == 0) begin
          report_mismatch("result with no pending item", '0, got_res,
                          m_tdata_i[OUT_DATA_W-1:11]);
        end else begin
          exp_res = expected_routes.pop_front();
          if (got_res != exp_res || m_tdata_i[OUT_DATA_W-1:11] != 0)
            report_mismatch("result mismatch", exp_res, got_res, m_tdata_i[OUT_DATA_W-1:11]);
        end
      end
    end
    pending_o = expected_routes.size();
  end

endmodule

// ----- verif/irq_least_count_balancer_tb.sv -----
module irq_least_count_balancer_tb
  import irq_lcb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 85;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches, pending, events, reroutes, clears;
  int idle_cycles = 0;
  int settings    = 0;
  int stall_pct   = 20;
  bit gaps_on     = 1'b1;
  bit hold_req    = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  irq_least_count_balancer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  irq_route_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .events_o     (events),
    .reroutes_o   (reroutes),
    .clears_o     (clears)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // caller sits on a falling edge; returns on the falling edge after acceptance
  task automatic push_event(logic [3:0] irq, logic [3:0] core);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? gap_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {core, irq};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // all four registers, junk in the unused upper bits
  task automatic set_config(logic bal, logic sym, logic [4:0] act, logic [15:0] per);
    logic [15:0] noise;
    noise = 16'($urandom());
    write_reg(CFG_BAL_EN, {noise[15:1], bal});
    noise = 16'($urandom());
    write_reg(CFG_SYM_IO, {noise[15:1], sym});
    noise = 16'($urandom());
    write_reg(CFG_ACT_CORES, {noise[15:5], act});
    write_reg(CFG_PERIOD, per);
    settings++;
  endtask

  // stop offering, let every result come back, then a short settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = gap_length();
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any accepted item or register write
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int          hot_irq;
    int          hot_cmax;
    logic [3:0]  irq;
    logic [3:0]  core;
    logic [15:0] per;
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_BAL_EN;
    cfg_wdata = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: balancing off, EOI to PIC
    push_event(4'd0, 4'd0);
    push_event(4'd15, 4'd15);
    wait_idle();

    // period 1 over all cores: every event reroutes
    set_config(1'b1, 1'b1, 5'd16, 16'd1);
    push_event(4'd0, 4'd0);
    push_event(4'd15, 4'd15);
    push_event(4'd15, 4'd0);
    push_event(4'd0, 4'd15);
    push_event(4'd5, 4'd3);
    push_event(4'd5, 4'd3);
    push_event(4'd5, 4'd0);
    wait_idle();

    // zero active cores and zero period act as one
    set_config(1'b1, 1'b0, 5'd0, 16'd0);
    push_event(4'd7, 4'd4);
    push_event(4'd7, 4'd0);
    push_event(4'd7, 4'd0);
    wait_idle();

    // active cores above the maximum clamp to all cores
    set_config(1'b1, 1'b1, 5'd31, 16'd2);
    push_event(4'd9, 4'd9);
    push_event(4'd9, 4'd9);
    push_event(4'd9, 4'd1);
    push_event(4'd9, 4'd1);
    wait_idle();

    // largest period: no hit
    set_config(1'b1, 1'b0, 5'd17, 16'hFFFF);
    push_event(4'd3, 4'd2);
    push_event(4'd3, 4'd2);
    wait_idle();

    set_config(1'b0, 1'b1, 5'd1, 16'd10);
    push_event(4'd1, 4'd1);
    wait_idle();

    // random phases: hot IRQ on cores 0..hot_cmax so counts climb through the period
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gaps_on   = (ph % 3 != 2);
      stall_pct = gaps_on ? $urandom_range(5, 40) : 0;
      if (ph == 2) hold_req = 1'b1;
      case ($urandom_range(0, 9))
        0:       per = 16'd0;
        1:       per = 16'd1;
        2:       per = 16'hFFFF;
        3:       per = 16'($urandom_range(0, 65535));
        default: per = 16'($urandom_range(2, 6));
      endcase
      if (ph == 0) per = 16'd1;
      set_config($urandom_range(0, 99) < 85, 1'($urandom_range(0, 1)),
                 5'($urandom_range(0, 31)), per);
      hot_irq  = $urandom_range(0, 15);
      hot_cmax = $urandom_range(0, 15);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 75) begin
          irq  = 4'(hot_irq);
          core = 4'($urandom_range(0, hot_cmax));
        end else begin
          irq  = 4'($urandom_range(0, 15));
          core = 4'($urandom_range(0, 15));
        end
        push_event(irq, core);
      end
      wait_idle();
    end

    repeat (80) @(negedge clk_i);
    $display("Ran %0d interrupt events under %0d register settings", events, settings);
    $display("Checked %0d rerouting decisions and %0d count clears", reroutes, clears);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
